// ===== rtl/core/wtts_pkg.sv =====
package wtts_pkg;

    localparam int WAKE_W = 32;
    localparam int ID_W   = 16;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_CREATE = 2'd1;
    localparam logic [1:0] KIND_SLEEP  = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_MAIN    = 2'd2;
    localparam logic [1:0] STATUS_WAITING = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [WAKE_W-1:0] now_ms;
        logic [WAKE_W-1:0] duration_ms;
    } req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] running_id;
        logic [ID_W-1:0] created_id;
        logic            switched;
        logic            idle_wait;
    } rsp_t;

    typedef struct packed {
        logic [WAKE_W-1:0] wake;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_HEAD_CMP,
        S_INS_RD,
        S_INS_CMP,
        S_INS_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       status_we;
        logic [1:0] status;
        logic       ins_start;
        logic       ins_rd;
        logic       ins_shift;
        logic       ins_commit;
        logic       rd_head;
        logic       pop;
        logic       finish;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       waiting;
        logic       queue_empty;
        logic       queue_full;
        logic       cur_main;
        logic       pos_one;
        logic       greater;
        logic       head_due;
        logic       rsp_free;
    } sts_t;

endpackage

// ===== rtl/core/wtts_ram.sv =====
module wtts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/wtts_ctrl.sv =====
module wtts_ctrl
    import wtts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STATUS_OK;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                if (sts.kind == KIND_TICK)
                begin
                    if (sts.waiting && !sts.queue_empty)
                    begin
                        cmd.rd_head = 1'b1;
                        state_next  = S_HEAD_CMP;
                    end
                end
                else if (sts.waiting)
                begin
                    cmd.status_we = 1'b1;
                    cmd.status    = STATUS_WAITING;
                end
                else if (sts.kind == KIND_FINISH)
                begin
                    if (sts.cur_main)
                    begin
                        cmd.status_we = 1'b1;
                        cmd.status    = STATUS_MAIN;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                    end
                end
                else if (sts.queue_full)
                begin
                    cmd.status_we = 1'b1;
                    cmd.status    = STATUS_FULL;
                end
                else
                begin
                    cmd.ins_start = 1'b1;
                    state_next    = sts.queue_empty ? S_INS_WR : S_INS_RD;
                end
            end
            S_HEAD_CMP:
            begin
                cmd.pop    = sts.head_due;
                state_next = S_DONE;
            end
            S_INS_RD:
            begin
                cmd.ins_rd = 1'b1;
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (sts.greater)
                begin
                    cmd.ins_shift = 1'b1;
                    if (sts.pos_one)
                    begin
                        state_next = S_INS_WR;
                    end
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.ins_commit = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (sts.rsp_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/wtts_datapath.sv =====
module wtts_datapath
    import wtts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp,
    input  cmd_t cmd,
    output sts_t sts
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    req_t            req_reg;
    entry_t          new_entry_reg;
    logic [1:0]      status_reg;
    logic [ID_W-1:0] created_reg;
    logic            switched_reg;
    rsp_t            rsp_reg;
    logic            rsp_valid_reg;
    logic [IW-1:0]   head_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   pos_reg;
    logic [ID_W-1:0] cur_reg;
    logic [ID_W-1:0] next_id_reg;
    logic            waiting_reg;
    logic            finished_reg;

    logic [WAKE_W:0]   wake_sum;
    logic [WAKE_W-1:0] sat_wake;
    logic [CW-1:0]     pos_m1;
    logic [CW-1:0]     pos_m2;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    entry_t            ram_rdata;
    logic [IW-1:0]     head_next;

    function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                           input logic [IW-1:0] lidx);
        logic [IW:0] s;
        s = {1'b0, head} + {1'b0, lidx};
        if (s >= (IW+1)'(QUEUE_DEPTH))
        begin
            s = s - (IW+1)'(QUEUE_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    assign wake_sum = {1'b0, req_reg.now_ms} + {1'b0, req_reg.duration_ms};
    assign sat_wake = wake_sum[WAKE_W] ? '1 : wake_sum[WAKE_W-1:0];
    assign pos_m1   = pos_reg - CW'(1);
    assign pos_m2   = pos_reg - CW'(2);
    assign head_next = (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);

    always_comb
    begin
        ram_we    = cmd.ins_shift | cmd.ins_commit;
        ram_waddr = phys(head_reg, pos_reg[IW-1:0]);
        ram_wdata = cmd.ins_commit ? new_entry_reg : ram_rdata;
        ram_re    = cmd.rd_head | cmd.ins_rd | (cmd.ins_shift & ~sts.pos_one);
        if (cmd.rd_head)
        begin
            ram_raddr = head_reg;
        end
        else if (cmd.ins_rd)
        begin
            ram_raddr = phys(head_reg, pos_m1[IW-1:0]);
        end
        else
        begin
            ram_raddr = phys(head_reg, pos_m2[IW-1:0]);
        end
    end

    wtts_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        sts.kind        = req_reg.kind;
        sts.waiting     = waiting_reg;
        sts.queue_empty = (count_reg == '0);
        sts.queue_full  = (count_reg == FULL_CNT);
        sts.cur_main    = (cur_reg == '0);
        sts.pos_one     = (pos_reg == CW'(1));
        sts.greater     = (ram_rdata.wake > new_entry_reg.wake);
        sts.head_due    = (ram_rdata.wake <= req_reg.now_ms);
        sts.rsp_free    = ~rsp_valid_reg | rsp_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= req;
            status_reg   <= STATUS_OK;
            created_reg  <= '0;
            switched_reg <= 1'b0;
        end
        if (cmd.status_we)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.ins_start)
        begin
            if (req_reg.kind == KIND_CREATE)
            begin
                new_entry_reg <= '{wake: '0, id: next_id_reg};
            end
            else
            begin
                new_entry_reg <= '{wake: sat_wake, id: cur_reg};
            end
        end
        if (cmd.ins_commit && (req_reg.kind == KIND_CREATE))
        begin
            created_reg <= next_id_reg;
        end
        if (cmd.pop)
        begin
            switched_reg <= finished_reg | (ram_rdata.id != cur_reg);
        end
        if (cmd.emit)
        begin
            rsp_reg <= '{status: status_reg, running_id: cur_reg,
                         created_id: created_reg, switched: switched_reg,
                         idle_wait: waiting_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            cur_reg       <= '0;
            next_id_reg   <= ID_W'(1);
            waiting_reg   <= 1'b0;
            finished_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cmd.ins_start)
            begin
                pos_reg <= count_reg;
            end
            if (cmd.ins_shift)
            begin
                pos_reg <= pos_m1;
            end
            if (cmd.ins_commit)
            begin
                count_reg <= count_reg + CW'(1);
                if (req_reg.kind == KIND_CREATE)
                begin
                    next_id_reg <= next_id_reg + ID_W'(1);
                end
                else
                begin
                    waiting_reg  <= 1'b1;
                    finished_reg <= 1'b0;
                end
            end
            if (cmd.finish)
            begin
                waiting_reg  <= 1'b1;
                finished_reg <= 1'b1;
            end
            if (cmd.pop)
            begin
                cur_reg      <= ram_rdata.id;
                head_reg     <= head_next;
                count_reg    <= count_reg - CW'(1);
                waiting_reg  <= 1'b0;
                finished_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("queue count exceeds the queue depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_commit |-> (count_reg < FULL_CNT))
        else $error("insertion into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> ((count_reg != '0) && waiting_reg))
        else $error("pop from an empty queue or outside a wait");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!rsp_valid_reg || rsp_ready))
        else $error("response overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> waiting_reg)
        else $error("finished flag set outside a wait");

endmodule

// ===== rtl/core/wake_time_task_scheduler.sv =====
// Keeps sleeping tasks in a queue sorted by wake time, in a single RAM used as a
// circular buffer, and answers each request with exactly one response. One
// request is handled at a time; the next is accepted once the response is in
// the output register, even if it has not been taken yet. A tick, finish or
// refused request passes from decode to the done state; a tick that reads the
// queue head while a wait is pending adds a head compare state, and a create
// or sleep adds an insertion write, preceded on a non-empty queue by a read
// state and a compare state that shifts each later-waking entry up one slot.
// A response still waiting in the output register holds the next one back
// until it is taken. The insertion walk moves one queue entry per cycle through
// the RAM's single write port. The queue RAM needs no clearing after reset.
module wake_time_task_scheduler
    import wtts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    wtts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wtts_datapath #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ===== test/wtts_checker.sv =====
module wtts_checker
    import wtts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding,
    output int   queued_hint,
    output logic main_hint,
    output logic waiting_hint,
    output int   switch_total,
    output int   full_total,
    output int   rsp_total
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 200;

    entry_t            sleepers [QUEUE_DEPTH];
    int unsigned       sleeper_count;
    logic [ID_W-1:0]   running;
    logic [ID_W-1:0]   next_id;
    logic              waiting;
    logic              by_finish;
    rsp_t              due_rsp [$];

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        switch_total = 0;
        full_total   = 0;
        rsp_total    = 0;
        queued_hint  = 0;
        main_hint    = 1'b1;
        waiting_hint = 1'b0;
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("[%0t] response %0d: %s", $realtime, rsp_total, what);
        end
    endtask

    function automatic void enqueue(input logic [ID_W-1:0] tid, input logic [WAKE_W-1:0] when_ms);
        int pos;
        pos = sleeper_count;
        while (pos > 0 && sleepers[pos-1].wake > when_ms)
        begin
            sleepers[pos] = sleepers[pos-1];
            pos--;
        end
        sleepers[pos] = '{wake: when_ms, id: tid};
        sleeper_count++;
    endfunction

    function automatic rsp_t schedule_step(input req_t r);
        rsp_t              o;
        logic [WAKE_W:0]   sum;
        logic [WAKE_W-1:0] when_ms;
        logic [ID_W-1:0]   popped;
        o = '0;
        o.status = STATUS_OK;
        if (r.kind == KIND_TICK)
        begin
            if (waiting && sleeper_count > 0 && sleepers[0].wake <= r.now_ms)
            begin
                popped = sleepers[0].id;
                for (int i = 1; i < sleeper_count; i++)
                begin
                    sleepers[i-1] = sleepers[i];
                end
                sleeper_count--;
                o.switched = by_finish || (popped != running);
                running    = popped;
                waiting    = 1'b0;
                by_finish  = 1'b0;
            end
        end
        else if (waiting)
        begin
            o.status = STATUS_WAITING;
        end
        else if (r.kind == KIND_CREATE)
        begin
            if (sleeper_count == QUEUE_DEPTH)
            begin
                o.status = STATUS_FULL;
            end
            else
            begin
                enqueue(next_id, '0);
                o.created_id = next_id;
                next_id++;
            end
        end
        else if (r.kind == KIND_SLEEP)
        begin
            sum = {1'b0, r.now_ms} + {1'b0, r.duration_ms};
            when_ms = sum[WAKE_W] ? '1 : sum[WAKE_W-1:0];
            if (sleeper_count == QUEUE_DEPTH)
            begin
                o.status = STATUS_FULL;
            end
            else
            begin
                enqueue(running, when_ms);
                waiting   = 1'b1;
                by_finish = 1'b0;
            end
        end
        else
        begin
            if (running == '0)
            begin
                o.status = STATUS_MAIN;
            end
            else
            begin
                waiting   = 1'b1;
                by_finish = 1'b1;
            end
        end
        o.running_id = running;
        o.idle_wait  = waiting;
        if (o.switched)
        begin
            switch_total++;
        end
        if (o.status == STATUS_FULL)
        begin
            full_total++;
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            sleeper_count = 0;
            running       = '0;
            next_id       = ID_W'(1);
            waiting       = 1'b0;
            by_finish     = 1'b0;
            due_rsp.delete();
            outstanding   = 0;
            queued_hint  <= 0;
            main_hint    <= 1'b1;
            waiting_hint <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_total++;
                if (due_rsp.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected response %p", rsp));
                end
                else
                begin
                    want = due_rsp.pop_front();
                    if (rsp.status !== want.status)
                        note_mismatch($sformatf("status %0d, expected %0d",
                                                rsp.status, want.status));
                    if (rsp.running_id !== want.running_id)
                        note_mismatch($sformatf("running_id %0d, expected %0d",
                                                rsp.running_id, want.running_id));
                    if (rsp.created_id !== want.created_id)
                        note_mismatch($sformatf("created_id %0d, expected %0d",
                                                rsp.created_id, want.created_id));
                    if (rsp.switched !== want.switched)
                        note_mismatch($sformatf("switched %b, expected %b",
                                                rsp.switched, want.switched));
                    if (rsp.idle_wait !== want.idle_wait)
                        note_mismatch($sformatf("idle_wait %b, expected %b",
                                                rsp.idle_wait, want.idle_wait));
                end
            end
            if (req_valid && req_ready)
            begin
                due_rsp.push_back(schedule_step(req));
            end
            outstanding = due_rsp.size();
            queued_hint  <= sleeper_count;
            main_hint    <= (running == '0);
            waiting_hint <= waiting;
        end
    end

endmodule

// ===== test/tb_wake_time_task_scheduler.sv =====
module tb_wake_time_task_scheduler;
    timeunit 1ns;
    timeprecision 1ps;
    import wtts_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int ITEM_TARGET = 850;
    localparam int STALL_LIMIT = 4000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int   mismatches;
    int   outstanding;
    int   queued_hint;
    logic main_hint;
    logic waiting_hint;
    int   switch_total;
    int   full_total;
    int   rsp_total;

    int          idle_cycles  = 0;
    int          sent         = 0;
    int          kind_sent [4] = '{default: 0};
    logic [31:0] clock_ms     = '0;
    bit          steady       = 1'b0;
    int          rest         = 0;

    wake_time_task_scheduler #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    wtts_checker #(
        .QUEUE_DEPTH(QDEPTH)
    ) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .queued_hint  (queued_hint),
        .main_hint    (main_hint),
        .waiting_hint (waiting_hint),
        .switch_total (switch_total),
        .full_total   (full_total),
        .rsp_total    (rsp_total)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        if (r < 92)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic int send_gap();
        if (steady || $urandom_range(0, 99) < 55)
            return 0;
        return pause_len();
    endfunction

    always @(posedge clk)
    begin
        if (rest > 0)
        begin
            rsp_ready <= 1'b0;
            rest <= rest - 1;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 20)
                rest <= pause_len();
        end
    end

    function automatic logic [31:0] tick_at();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '1;
        if (r < 12)
            return $urandom();
        return clock_ms + $urandom_range(0, 40);
    endfunction

    function automatic logic [31:0] sleep_for();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 30);
        if (r < 85)
            return $urandom_range(0, 2000);
        if (r < 94)
            return $urandom();
        return '1;
    endfunction

    task automatic send(input logic [1:0] kind, input logic [31:0] now_ms,
                        input logic [31:0] duration_ms);
        int gap;
        gap = send_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{kind: kind, now_ms: now_ms, duration_ms: duration_ms};
        do
            @(posedge clk);
        while (!req_ready);
        sent++;
        kind_sent[kind]++;
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // The main task is always either running or queued, so a full queue only
    // blocks progress while it runs; creates therefore stop short of full
    // except here, where the scheduler is known to be running another task.
    task automatic fill_queue();
        int room;
        settle();
        if (!waiting_hint && !main_hint)
        begin
            room = QDEPTH - queued_hint;
            repeat (room) send(KIND_CREATE, clock_ms, $urandom());
            send(KIND_CREATE, $urandom(), $urandom());
            send(KIND_SLEEP, clock_ms, 32'd1);
            send(KIND_FINISH, clock_ms, $urandom());
        end
    endtask

    function automatic bit room_for_create();
        return queued_hint <= QDEPTH - 3;
    endfunction

    initial
    begin
        int          r;
        logic [1:0]  k;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(KIND_TICK, 32'd0, 32'd0);
        send(KIND_FINISH, 32'd0, '1);
        send(KIND_SLEEP, 32'd10, 32'd0);
        send(KIND_CREATE, 32'd10, 32'd0);
        send(KIND_SLEEP, 32'd10, 32'd0);
        send(KIND_FINISH, 32'd10, 32'd0);
        send(KIND_TICK, 32'd9, 32'd0);
        send(KIND_TICK, 32'd10, 32'd0);
        send(KIND_CREATE, 32'd11, 32'd0);
        send(KIND_CREATE, 32'd11, 32'd0);
        send(KIND_CREATE, 32'd11, 32'd0);
        send(KIND_SLEEP, 32'hFFFF_FFF0, 32'h0000_0100);
        send(KIND_TICK, 32'd0, 32'd0);
        send(KIND_SLEEP, 32'd20, 32'd5);
        send(KIND_TICK, 32'd0, 32'd0);
        send(KIND_SLEEP, 32'd20, 32'd5);
        send(KIND_TICK, 32'd0, 32'd0);
        send(KIND_FINISH, 32'd20, 32'd0);
        send(KIND_TICK, 32'd24, 32'd0);
        send(KIND_TICK, 32'd25, 32'd0);
        send(KIND_SLEEP, 32'd26, 32'd0);
        send(KIND_TICK, 32'd30, '1);
        clock_ms = 32'd30;
        fill_queue();

        while (sent < ITEM_TARGET)
        begin
            steady = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 38)
            begin
                if ($urandom_range(0, 2) == 0)
                    send(KIND_FINISH, clock_ms, $urandom());
                else
                    send(KIND_SLEEP, clock_ms, sleep_for());
                repeat ($urandom_range(1, 4))
                begin
                    clock_ms += $urandom_range(0, 15);
                    send(KIND_TICK, tick_at(), $urandom());
                end
            end
            else if (r < 62)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    if (room_for_create())
                        send(KIND_CREATE, clock_ms, $urandom());
                    else
                        send(KIND_TICK, tick_at(), $urandom());
                end
            end
            else if (r < 75)
            begin
                k = 2'($urandom_range(0, 3));
                if (k == KIND_CREATE && !room_for_create())
                    k = KIND_TICK;
                send(k, $urandom(), $urandom());
            end
            else if (r < 88)
            begin
                clock_ms += $urandom_range(0, 200);
                send(KIND_TICK, tick_at(), $urandom());
            end
            else if (r < 92)
            begin
                fill_queue();
            end
            else
            begin
                settle();
                send(KIND_SLEEP, clock_ms, sleep_for());
            end
        end

        steady = 1'b0;
        req_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (QDEPTH + 8) @(posedge clk);

        $display("Sent %0d requests: %0d ticks, %0d creates, %0d sleeps, %0d finishes.",
                 sent, kind_sent[KIND_TICK], kind_sent[KIND_CREATE],
                 kind_sent[KIND_SLEEP], kind_sent[KIND_FINISH]);
        $display("Checked %0d responses, with %0d task switches and %0d full-queue refusals.",
                 rsp_total, switch_total, full_total);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
